/* hw/rtl/ilhp_pkg.sv */
// Shared types and constants for the IPv4 / L4 header parser.
`timescale 1ns / 1ps

package ilhp_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 16384;
	localparam int unsigned IDX_W = 16;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [IDX_W-1:0] ETH_HDR_BYTES = 16'd14;
	localparam logic [IDX_W-1:0] WORD_BYTES = 16'd4;
	localparam logic [IDX_W-1:0] POS_TYPE_HI = 16'd12;
	localparam logic [IDX_W-1:0] POS_TYPE_LO = 16'd13;
	localparam logic [IDX_W-1:0] POS_IHL = 16'd14;
	localparam logic [IDX_W-1:0] POS_PROTO = 16'd23;
	localparam logic [IDX_W-1:0] POS_SRC_FIRST = 16'd26;
	localparam logic [IDX_W-1:0] POS_SRC_LAST = 16'd29;
	localparam logic [IDX_W-1:0] POS_DST_FIRST = 16'd30;
	localparam logic [IDX_W-1:0] POS_DST_LAST = 16'd33;
	localparam logic [IDX_W-1:0] IP_MIN_END = 16'd34;
	localparam logic [IDX_W-1:0] TCP_HDR_BYTES = 16'd20;
	localparam logic [IDX_W-1:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [IDX_W-1:0] MAX_IDX = 16'(MAX_FRAME_BYTES);
	localparam logic [3:0] MIN_WORDS = 4'd5;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [3:0] ST_TCP = 4'd0;
	localparam logic [3:0] ST_UDP = 4'd1;
	localparam logic [3:0] ST_ICMP = 4'd2;
	localparam logic [3:0] ST_OTHER = 4'd3;
	localparam logic [3:0] ST_SHORT = 4'd4;
	localparam logic [3:0] ST_NOT_IPV4 = 4'd5;
	localparam logic [3:0] ST_IP_TRUNC = 4'd6;
	localparam logic [3:0] ST_L4_TRUNC = 4'd7;
	localparam logic [3:0] ST_MALFORMED = 4'd8;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic last_byte;
	} hdr_in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic end_of_frame;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [7:0] ip_protocol;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
		logic [7:0] tcp_flag_bits;
		logic [3:0] parse_status;
	} hdr_out_t;

	typedef struct packed {
		logic [IDX_W-1:0] len;
		logic [15:0] ether_kind;
		logic [3:0] header_words;
		logic [7:0] proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] port_src;
		logic [15:0] port_dst;
		logic [31:0] seq_value;
		logic [31:0] ack_value;
		logic [7:0] flag_value;
		logic [3:0] data_offset_words;
	} hdr_snap_t;

	typedef struct packed {
		logic has_pay;
		logic [7:0] pay_byte;
		logic has_sum;
		hdr_snap_t snap;
	} ilhp_entry_t;

endpackage

/* hw/rtl/ilhp_front.sv */
// Front end: accepts frame bytes, captures header fields, classifies each byte.
`timescale 1ns / 1ps

module ilhp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  ilhp_pkg::hdr_in_t    byte_data,
	input  logic                 q_full,
	output logic                 q_push,
	output ilhp_pkg::ilhp_entry_t q_entry,
	output logic                 byte_stall
);

	ilhp_pkg::hdr_snap_t st_q;
	ilhp_pkg::hdr_snap_t st_n;
	logic pay;
	logic accept;
	logic [ilhp_pkg::IDX_W-1:0] idx;
	logic [ilhp_pkg::IDX_W-1:0] l4;
	logic [ilhp_pkg::IDX_W-1:0] rel;
	logic [ilhp_pkg::IDX_W-1:0] doff_bytes;
	logic [7:0] b;

	assign byte_stall = q_full;
	assign accept = byte_valid && !q_full;
	assign idx = st_q.len;
	assign b = byte_data.frame_byte;
	assign l4 = ilhp_pkg::ETH_HDR_BYTES + {10'd0, st_q.header_words, 2'b00};
	assign rel = idx - l4;
	assign doff_bytes = {10'd0, st_q.data_offset_words, 2'b00};

	always_comb begin
		st_n = st_q;
		pay = 1'b0;
		if (idx < ilhp_pkg::MAX_IDX) begin
			st_n.len = idx + 16'd1;
			if (idx == ilhp_pkg::POS_TYPE_HI || idx == ilhp_pkg::POS_TYPE_LO) begin
				st_n.ether_kind = {st_q.ether_kind[7:0], b};
			end else if (idx >= ilhp_pkg::ETH_HDR_BYTES
					&& st_q.ether_kind == ilhp_pkg::ETHERTYPE_IPV4) begin
				if (idx == ilhp_pkg::POS_IHL) begin
					st_n.header_words = b[3:0];
				end else if (idx == ilhp_pkg::POS_PROTO) begin
					st_n.proto = b;
				end else if (idx >= ilhp_pkg::POS_SRC_FIRST && idx <= ilhp_pkg::POS_SRC_LAST) begin
					st_n.src_addr = {st_q.src_addr[23:0], b};
				end else if (idx >= ilhp_pkg::POS_DST_FIRST && idx <= ilhp_pkg::POS_DST_LAST) begin
					st_n.dst_addr = {st_q.dst_addr[23:0], b};
				end else if (st_q.header_words >= ilhp_pkg::MIN_WORDS && idx >= l4) begin
					if (st_q.proto == ilhp_pkg::PROTO_TCP) begin
						if (rel <= 16'd1) st_n.port_src = {st_q.port_src[7:0], b};
						else if (rel <= 16'd3) st_n.port_dst = {st_q.port_dst[7:0], b};
						else if (rel <= 16'd7) st_n.seq_value = {st_q.seq_value[23:0], b};
						else if (rel <= 16'd11) st_n.ack_value = {st_q.ack_value[23:0], b};
						else if (rel == 16'd12) st_n.data_offset_words = b[7:4];
						else if (rel == 16'd13) st_n.flag_value = b;
						else if (rel >= ilhp_pkg::TCP_HDR_BYTES
								&& st_q.data_offset_words >= ilhp_pkg::MIN_WORDS
								&& rel >= doff_bytes) pay = 1'b1;
					end else if (st_q.proto == ilhp_pkg::PROTO_UDP) begin
						if (rel <= 16'd1) st_n.port_src = {st_q.port_src[7:0], b};
						else if (rel <= 16'd3) st_n.port_dst = {st_q.port_dst[7:0], b};
						else if (rel >= ilhp_pkg::UDP_HDR_BYTES) pay = 1'b1;
					end else begin
						pay = (st_q.proto == ilhp_pkg::PROTO_ICMP);
					end
				end
			end
		end
	end

	assign q_entry.has_pay = pay;
	assign q_entry.pay_byte = b;
	assign q_entry.has_sum = byte_data.last_byte;
	assign q_entry.snap = st_n;
	assign q_push = accept && (pay || byte_data.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			if (byte_data.last_byte) st_q <= '0;
			else st_q <= st_n;
		end
	end

endmodule

/* hw/rtl/ilhp_queue.sv */
// Short queue of classified bytes between front and back.
`timescale 1ns / 1ps

module ilhp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ilhp_pkg::ilhp_entry_t push_entry,
	input  logic                  pop,
	output logic                  full,
	output logic                  not_empty,
	output ilhp_pkg::ilhp_entry_t head
);

	ilhp_pkg::ilhp_entry_t ent_q [ilhp_pkg::QUEUE_DEPTH];
	logic [ilhp_pkg::QPTR_W-1:0] wr_q;
	logic [ilhp_pkg::QPTR_W-1:0] rd_q;
	logic [ilhp_pkg::QCNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	localparam logic [ilhp_pkg::QPTR_W-1:0] LAST_PTR =
		ilhp_pkg::QPTR_W'(ilhp_pkg::QUEUE_DEPTH - 1);
	localparam logic [ilhp_pkg::QCNT_W-1:0] FULL_CNT =
		ilhp_pkg::QCNT_W'(ilhp_pkg::QUEUE_DEPTH);

	assign full = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign head = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/ilhp_back.sv */
// Back end: judges the frame status and drives the result register.
`timescale 1ns / 1ps

module ilhp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  ilhp_pkg::ilhp_entry_t q_head,
	output logic                  q_pop,
	output logic                  result_valid,
	output ilhp_pkg::hdr_out_t    result_data,
	input  logic                  result_stall
);

	ilhp_pkg::hdr_out_t res_q;
	ilhp_pkg::hdr_out_t pay_res;
	ilhp_pkg::hdr_out_t sum_res;
	ilhp_pkg::hdr_snap_t s;
	logic res_valid_q;
	logic phase_q;
	logic load;
	logic emit_pay;
	logic ip_shown;
	logic ports_shown;
	logic tcp_shown;
	logic [3:0] status;
	logic [ilhp_pkg::IDX_W-1:0] l4;

	assign s = q_head.snap;
	assign l4 = ilhp_pkg::ETH_HDR_BYTES + {10'd0, s.header_words, 2'b00};

	always_comb begin
		ip_shown = 1'b0;
		ports_shown = 1'b0;
		tcp_shown = 1'b0;
		if (s.len < ilhp_pkg::ETH_HDR_BYTES) begin
			status = ilhp_pkg::ST_SHORT;
		end else if (s.ether_kind != ilhp_pkg::ETHERTYPE_IPV4) begin
			status = ilhp_pkg::ST_NOT_IPV4;
		end else if (s.len < ilhp_pkg::IP_MIN_END) begin
			status = ilhp_pkg::ST_IP_TRUNC;
		end else begin
			ip_shown = 1'b1;
			if (s.header_words < ilhp_pkg::MIN_WORDS) begin
				status = ilhp_pkg::ST_MALFORMED;
			end else if (s.len < l4) begin
				status = ilhp_pkg::ST_IP_TRUNC;
			end else if (s.proto == ilhp_pkg::PROTO_TCP) begin
				if (s.len < l4 + ilhp_pkg::TCP_HDR_BYTES) begin
					status = ilhp_pkg::ST_L4_TRUNC;
				end else begin
					ports_shown = 1'b1;
					tcp_shown = 1'b1;
					status = (s.data_offset_words < ilhp_pkg::MIN_WORDS) ?
						ilhp_pkg::ST_MALFORMED : ilhp_pkg::ST_TCP;
				end
			end else if (s.proto == ilhp_pkg::PROTO_UDP) begin
				if (s.len < l4 + ilhp_pkg::UDP_HDR_BYTES) begin
					status = ilhp_pkg::ST_L4_TRUNC;
				end else begin
					ports_shown = 1'b1;
					status = ilhp_pkg::ST_UDP;
				end
			end else if (s.proto == ilhp_pkg::PROTO_ICMP) begin
				status = ilhp_pkg::ST_ICMP;
			end else begin
				status = ilhp_pkg::ST_OTHER;
			end
		end
	end

	always_comb begin
		pay_res = '0;
		pay_res.payload_byte = q_head.pay_byte;
		sum_res = '0;
		sum_res.end_of_frame = 1'b1;
		sum_res.src_address = ip_shown ? s.src_addr : '0;
		sum_res.dst_address = ip_shown ? s.dst_addr : '0;
		sum_res.ip_protocol = ip_shown ? s.proto : '0;
		sum_res.src_port = ports_shown ? s.port_src : '0;
		sum_res.dst_port = ports_shown ? s.port_dst : '0;
		sum_res.seq_number = tcp_shown ? s.seq_value : '0;
		sum_res.ack_number = tcp_shown ? s.ack_value : '0;
		sum_res.tcp_flag_bits = tcp_shown ? s.flag_value : '0;
		sum_res.parse_status = status;
	end

	assign load = q_not_empty && (!res_valid_q || !result_stall);
	assign emit_pay = q_head.has_pay && !phase_q;
	assign q_pop = load && !(emit_pay && q_head.has_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
			if (load) phase_q <= emit_pay && q_head.has_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= emit_pay ? pay_res : sum_res;
	end

	assign result_valid = res_valid_q;
	assign result_data = res_q;

endmodule

/* hw/rtl/ipv4_l4_header_parser_top.sv */
// Top level of the Ethernet / IPv4 / TCP-UDP header parser.
// channel | dir | handshake                  | payload
// byte    | in  | byte_valid / byte_stall     | byte_data   (hdr_in_t)
// result  | out | result_valid / result_stall | result_data (hdr_out_t)
// One byte is taken every cycle unless byte_stall is high; the front registers header fields as each byte is accepted.
// A payload result passes through the queue and then the result register; a summary follows it.
// A final byte that is also payload yields two results, the payload first and then the summary.
// A four-entry queue decouples the sides; byte_stall rises only when it is full.
// Reset clears all header state and empties the queue.
`timescale 1ns / 1ps

module ipv4_l4_header_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  ilhp_pkg::hdr_in_t  byte_data,
	output logic               byte_stall,
	output logic               result_valid,
	output ilhp_pkg::hdr_out_t result_data,
	input  logic               result_stall
);

	ilhp_pkg::ilhp_entry_t push_entry;
	ilhp_pkg::ilhp_entry_t head;
	logic push;
	logic pop;
	logic full;
	logic not_empty;

	ilhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_data  (byte_data),
		.q_full     (full),
		.q_push     (push),
		.q_entry    (push_entry),
		.byte_stall (byte_stall)
	);

	ilhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.not_empty  (not_empty),
		.head       (head)
	);

	ilhp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (not_empty),
		.q_head       (head),
		.q_pop        (pop),
		.result_valid (result_valid),
		.result_data  (result_data),
		.result_stall (result_stall)
	);

endmodule

/* hw/rtl/ilhp_checker.sv */
// Port-level assertions for the header parser, bound to the top level.
`timescale 1ns / 1ps

module ilhp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               byte_valid,
	input ilhp_pkg::hdr_in_t  byte_data,
	input logic               byte_stall,
	input logic               result_valid,
	input ilhp_pkg::hdr_out_t result_data,
	input logic               result_stall
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result transfer dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_data))
		else $error("stalled result changed");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.end_of_frame |->
			result_data.parse_status == ilhp_pkg::ST_TCP
			&& result_data.src_address == '0 && result_data.src_port == '0
			&& result_data.seq_number == '0)
		else $error("payload transfer carries header fields");

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.end_of_frame |->
			result_data.payload_byte == '0
			&& result_data.parse_status <= ilhp_pkg::ST_MALFORMED)
		else $error("bad summary transfer");

	a_stall_frees: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !byte_valid |=> !byte_stall || !$past(byte_stall))
		else $error("input stalled with idle output");

endmodule

bind ipv4_l4_header_parser_top ilhp_checker u_ilhp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_data    (byte_data),
	.byte_stall   (byte_stall),
	.result_valid (result_valid),
	.result_data  (result_data),
	.result_stall (result_stall)
);

/* tb/ipv4_l4_header_parser_top_test.sv */
// Self-checking testbench for the Ethernet / IPv4 / TCP-UDP header parser.
`timescale 1ns / 1ps

module ipv4_l4_header_parser_top_test;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                byte_valid = 1'b0;
	ilhp_pkg::hdr_in_t   byte_data = '0;
	logic                byte_stall;
	logic                result_valid;
	ilhp_pkg::hdr_out_t  result_data;
	logic                result_stall = 1'b0;

	ipv4_l4_header_parser_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_data    (byte_data),
		.byte_stall   (byte_stall),
		.result_valid (result_valid),
		.result_data  (result_data),
		.result_stall (result_stall)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Parser state mirrored in the testbench
	int          frame_len = 0;
	logic [15:0] ether_word = '0;
	logic [3:0]  ihl_words = '0;
	logic [7:0]  proto = '0;
	logic [31:0] src_ip = '0;
	logic [31:0] dst_ip = '0;
	logic [15:0] sport = '0;
	logic [15:0] dport = '0;
	logic [31:0] seq_num = '0;
	logic [31:0] ack_num = '0;
	logic [7:0]  tcp_flags = '0;
	logic [3:0]  tcp_doff = '0;

	ilhp_pkg::hdr_out_t frame_results_q[$];
	logic [7:0]  frame_buf[$];
	int          mismatches = 0;
	bit          idling = 1'b0;
	int          long_hold = 0;

	task automatic parse_frame_byte(input logic [7:0] b, input logic last);
		int       l4;
		int       rel;
		bit       is_payload;
		bit       ip_shown;
		bit       ports_shown;
		bit       tcp_shown;
		logic [3:0] st;
		ilhp_pkg::hdr_out_t r;
		is_payload = 1'b0;
		l4 = int'(ilhp_pkg::ETH_HDR_BYTES) + int'(ihl_words) * int'(ilhp_pkg::WORD_BYTES);
		if (frame_len < int'(ilhp_pkg::MAX_FRAME_BYTES)) begin
			if (frame_len == ilhp_pkg::POS_TYPE_HI || frame_len == ilhp_pkg::POS_TYPE_LO) begin
				ether_word = {ether_word[7:0], b};
			end else if (frame_len >= ilhp_pkg::ETH_HDR_BYTES
					&& ether_word == ilhp_pkg::ETHERTYPE_IPV4) begin
				if (frame_len == ilhp_pkg::POS_IHL) begin
					ihl_words = b[3:0];
				end else if (frame_len == ilhp_pkg::POS_PROTO) begin
					proto = b;
				end else if (frame_len >= ilhp_pkg::POS_SRC_FIRST
						&& frame_len <= ilhp_pkg::POS_SRC_LAST) begin
					src_ip = {src_ip[23:0], b};
				end else if (frame_len >= ilhp_pkg::POS_DST_FIRST
						&& frame_len <= ilhp_pkg::POS_DST_LAST) begin
					dst_ip = {dst_ip[23:0], b};
				end else if (ihl_words >= ilhp_pkg::MIN_WORDS && frame_len >= l4) begin
					rel = frame_len - l4;
					if (proto == ilhp_pkg::PROTO_TCP) begin
						if (rel <= 1) sport = {sport[7:0], b};
						else if (rel <= 3) dport = {dport[7:0], b};
						else if (rel <= 7) seq_num = {seq_num[23:0], b};
						else if (rel <= 11) ack_num = {ack_num[23:0], b};
						else if (rel == 12) tcp_doff = b[7:4];
						else if (rel == 13) tcp_flags = b;
						else if (rel >= ilhp_pkg::TCP_HDR_BYTES
								&& tcp_doff >= ilhp_pkg::MIN_WORDS
								&& rel >= int'(tcp_doff) * int'(ilhp_pkg::WORD_BYTES))
							is_payload = 1'b1;
					end else if (proto == ilhp_pkg::PROTO_UDP) begin
						if (rel <= 1) sport = {sport[7:0], b};
						else if (rel <= 3) dport = {dport[7:0], b};
						else if (rel >= ilhp_pkg::UDP_HDR_BYTES) is_payload = 1'b1;
					end else begin
						is_payload = (proto == ilhp_pkg::PROTO_ICMP);
					end
				end
			end
			frame_len++;
			if (is_payload) begin
				r = '0;
				r.payload_byte = b;
				frame_results_q.push_back(r);
			end
		end
		if (last) begin
			ip_shown = 1'b0;
			ports_shown = 1'b0;
			tcp_shown = 1'b0;
			if (frame_len < ilhp_pkg::ETH_HDR_BYTES) st = ilhp_pkg::ST_SHORT;
			else if (ether_word != ilhp_pkg::ETHERTYPE_IPV4) st = ilhp_pkg::ST_NOT_IPV4;
			else if (frame_len < ilhp_pkg::IP_MIN_END) st = ilhp_pkg::ST_IP_TRUNC;
			else begin
				ip_shown = 1'b1;
				if (ihl_words < ilhp_pkg::MIN_WORDS) st = ilhp_pkg::ST_MALFORMED;
				else if (frame_len < l4) st = ilhp_pkg::ST_IP_TRUNC;
				else if (proto == ilhp_pkg::PROTO_TCP) begin
					if (frame_len < l4 + int'(ilhp_pkg::TCP_HDR_BYTES)) begin
						st = ilhp_pkg::ST_L4_TRUNC;
					end else begin
						ports_shown = 1'b1;
						tcp_shown = 1'b1;
						st = (tcp_doff < ilhp_pkg::MIN_WORDS) ?
							ilhp_pkg::ST_MALFORMED : ilhp_pkg::ST_TCP;
					end
				end else if (proto == ilhp_pkg::PROTO_UDP) begin
					if (frame_len < l4 + int'(ilhp_pkg::UDP_HDR_BYTES)) begin
						st = ilhp_pkg::ST_L4_TRUNC;
					end else begin
						ports_shown = 1'b1;
						st = ilhp_pkg::ST_UDP;
					end
				end else if (proto == ilhp_pkg::PROTO_ICMP) st = ilhp_pkg::ST_ICMP;
				else st = ilhp_pkg::ST_OTHER;
			end
			r = '0;
			r.end_of_frame = 1'b1;
			if (ip_shown) begin
				r.src_address = src_ip;
				r.dst_address = dst_ip;
				r.ip_protocol = proto;
			end
			if (ports_shown) begin
				r.src_port = sport;
				r.dst_port = dport;
			end
			if (tcp_shown) begin
				r.seq_number = seq_num;
				r.ack_number = ack_num;
				r.tcp_flag_bits = tcp_flags;
			end
			r.parse_status = st;
			frame_results_q.push_back(r);
			frame_len = 0;
			ether_word = '0;
			ihl_words = '0;
			proto = '0;
			src_ip = '0;
			dst_ip = '0;
			sport = '0;
			dport = '0;
			seq_num = '0;
			ack_num = '0;
			tcp_flags = '0;
			tcp_doff = '0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idling && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= {b, last};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		parse_frame_byte(b, last);
	endtask

	task automatic send_buf();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic build_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
			input logic [7:0] prot, input logic [3:0] doff);
		int l4;
		frame_buf = {};
		for (int i = 0; i < len; i++)
			frame_buf.push_back(8'($urandom));
		l4 = int'(ilhp_pkg::ETH_HDR_BYTES) + int'(ihl) * int'(ilhp_pkg::WORD_BYTES);
		if (len > ilhp_pkg::POS_TYPE_HI) frame_buf[ilhp_pkg::POS_TYPE_HI] = etype[15:8];
		if (len > ilhp_pkg::POS_TYPE_LO) frame_buf[ilhp_pkg::POS_TYPE_LO] = etype[7:0];
		if (len > ilhp_pkg::POS_IHL)
			frame_buf[ilhp_pkg::POS_IHL] = {frame_buf[ilhp_pkg::POS_IHL][7:4], ihl};
		if (len > ilhp_pkg::POS_PROTO) frame_buf[ilhp_pkg::POS_PROTO] = prot;
		if (ihl >= ilhp_pkg::MIN_WORDS && len > l4 + 12)
			frame_buf[l4 + 12] = {doff, frame_buf[l4 + 12][3:0]};
	endtask

	task automatic send_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
			input logic [7:0] prot, input logic [3:0] doff);
		build_frame(len, etype, ihl, prot, doff);
		send_buf();
	endtask

	task automatic test_short_frames();
		send_frame(1, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd5);
		send_frame(13, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd5);
		send_frame(14, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd5);
	endtask

	task automatic test_byte_extremes();
		frame_buf = {};
		repeat (20) frame_buf.push_back(8'hFF);
		send_buf();
		frame_buf = {};
		repeat (20) frame_buf.push_back(8'h00);
		send_buf();
		send_frame(20, 16'h86DD, 4'd5, ilhp_pkg::PROTO_UDP, 4'd5);
	endtask

	task automatic test_ip_header();
		send_frame(33, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_UDP, 4'd5);
		send_frame(34, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, 8'd0, 4'd5);
		send_frame(40, ilhp_pkg::ETHERTYPE_IPV4, 4'd8, ilhp_pkg::PROTO_TCP, 4'd5);
	endtask

	task automatic test_malformed();
		send_frame(36, ilhp_pkg::ETHERTYPE_IPV4, 4'd4, ilhp_pkg::PROTO_TCP, 4'd5);
		send_frame(36, ilhp_pkg::ETHERTYPE_IPV4, 4'd0, ilhp_pkg::PROTO_ICMP, 4'd5);
		send_frame(64, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd4);
		send_frame(60, ilhp_pkg::ETHERTYPE_IPV4, 4'd6, ilhp_pkg::PROTO_TCP, 4'd0);
	endtask

	task automatic test_tcp();
		send_frame(14 + 20 + 20 + 4, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd5);
		send_frame(14 + 20 + 60 + 2, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP,
			4'd15);
		send_frame(14 + 20 + 19, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd5);
		send_frame(14 + 20 + 20, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd5);
		send_frame(14 + 20 + 30, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd8);
	endtask

	task automatic test_udp();
		send_frame(14 + 20 + 8 + 4, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_UDP, 4'd5);
		send_frame(14 + 20 + 7, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_UDP, 4'd5);
		send_frame(14 + 20 + 8, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_UDP, 4'd5);
	endtask

	task automatic test_icmp_and_other();
		send_frame(14 + 20 + 6, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_ICMP, 4'd5);
		send_frame(14 + 60 + 4, ilhp_pkg::ETHERTYPE_IPV4, 4'd15, ilhp_pkg::PROTO_ICMP, 4'd5);
		send_frame(14 + 60 - 1, ilhp_pkg::ETHERTYPE_IPV4, 4'd15, ilhp_pkg::PROTO_ICMP, 4'd5);
		send_frame(36, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, 8'd255, 4'd5);
	endtask

	task automatic test_backpressure();
		bit was_idling;
		was_idling = idling;
		idling = 1'b0;
		long_hold = 80;
		send_frame(60, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_ICMP, 4'd5);
		long_hold = 60;
		send_frame(64, ilhp_pkg::ETHERTYPE_IPV4, 4'd5, ilhp_pkg::PROTO_TCP, 4'd5);
		idling = was_idling;
	endtask

	task automatic test_random_frames(input int byte_goal);
		int          sent;
		int          hdr_end;
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [3:0]  doff;
		logic [7:0]  prot;
		sent = 0;
		while (sent < byte_goal) begin
			etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ilhp_pkg::ETHERTYPE_IPV4;
			if ($urandom_range(0, 11) == 0) ihl = 4'($urandom_range(0, 4));
			else if ($urandom_range(0, 19) == 0) ihl = 4'd15;
			else ihl = 4'($urandom_range(5, 7));
			if ($urandom_range(0, 9) == 0) doff = 4'($urandom_range(0, 4));
			else if ($urandom_range(0, 19) == 0) doff = 4'd15;
			else doff = 4'($urandom_range(5, 7));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: prot = ilhp_pkg::PROTO_TCP;
				4, 5, 6: prot = ilhp_pkg::PROTO_UDP;
				7, 8: prot = ilhp_pkg::PROTO_ICMP;
				default: prot = 8'($urandom);
			endcase
			hdr_end = int'(ilhp_pkg::ETH_HDR_BYTES)
				+ 4 * ((ihl < ilhp_pkg::MIN_WORDS) ? 5 : int'(ihl));
			if (prot == ilhp_pkg::PROTO_TCP)
				hdr_end += 4 * ((doff < ilhp_pkg::MIN_WORDS) ? 5 : int'(doff));
			else if (prot == ilhp_pkg::PROTO_UDP)
				hdr_end += int'(ilhp_pkg::UDP_HDR_BYTES);
			if ($urandom_range(0, 7) == 0) build_frame($urandom_range(1, hdr_end + 20),
					etype, ihl, prot, doff);
			else build_frame(hdr_end + $urandom_range(0, 24), etype, ihl, prot, doff);
			sent += frame_buf.size();
			send_buf();
		end
	endtask

	// Result side: random hold bursts, or a long hold when asked
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				stall_left = long_hold;
				long_hold = 0;
			end else if (stall_left == 0 && idling && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		ilhp_pkg::hdr_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (frame_results_q.size() == 0) begin
				$display("%0t: result transfer expected none, got %h", $time, result_data);
				mismatches++;
			end else begin
				want = frame_results_q.pop_front();
				check_field("payload_byte", 32'(want.payload_byte),
					32'(result_data.payload_byte));
				check_field("end_of_frame", 32'(want.end_of_frame),
					32'(result_data.end_of_frame));
				check_field("src_address", want.src_address, result_data.src_address);
				check_field("dst_address", want.dst_address, result_data.dst_address);
				check_field("ip_protocol", 32'(want.ip_protocol),
					32'(result_data.ip_protocol));
				check_field("src_port", 32'(want.src_port), 32'(result_data.src_port));
				check_field("dst_port", 32'(want.dst_port), 32'(result_data.dst_port));
				check_field("seq_number", want.seq_number, result_data.seq_number);
				check_field("ack_number", want.ack_number, result_data.ack_number);
				check_field("tcp_flag_bits", 32'(want.tcp_flag_bits),
					32'(result_data.tcp_flag_bits));
				check_field("parse_status", 32'(want.parse_status),
					32'(result_data.parse_status));
			end
		end
	end

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling = 1'b1;
		test_short_frames();
		test_byte_extremes();
		test_ip_header();
		test_malformed();
		test_tcp();
		test_udp();
		test_icmp_and_other();
		test_backpressure();
		test_random_frames(60);
		idling = 1'b0;
		test_random_frames(30);
		byte_valid <= 1'b0;
		waited = 0;
		while (frame_results_q.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (frame_results_q.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, frame_results_q.size());
		if (mismatches == 0 && frame_results_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("Mismatches found");
		$finish;
	end

endmodule
